FILE: rtl/bdf_pkg.sv
`timescale 1ns / 1ps

package bdf_pkg;

	// hash mixing constants and default clear interval
	localparam logic [31:0] ROUND_MUL        = 32'hC2B2AE35;
	localparam logic [31:0] FINAL_MUL        = 32'h85EBCA77;
	localparam logic [31:0] DEFAULT_INTERVAL = 32'd300000;

	// one seed per hash lane
	localparam int NUM_HASH = 3;
	localparam logic [31:0] SEEDS [NUM_HASH] = '{32'hDEADBEEF, 32'hCAFEBABE, 32'hABCD1234};

	// bit store is organised as rows of 32 bits
	localparam int ROW_BITS  = 32;
	localparam int ROW_SEL_W = 5;

	// sender byte counter, at most eight bytes
	localparam int BYTE_CNT_W = 3;

	typedef enum logic [1:0] {
		OP_CHECK     = 2'd0,
		OP_ADD       = 2'd1,
		OP_CHECK_ADD = 2'd2,
		OP_TICK      = 2'd3
	} op_t;

	// strobes from the sequencer to the bit store
	typedef struct packed {
		logic clear_req;
		logic rd_en;
		logic wr_en;
	} store_ctl_t;

endpackage

FILE: rtl/bdf_if.sv
`timescale 1ns / 1ps

// packet word into the filter
interface bdf_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [63:0] timestamp;
	logic [63:0] origin_id;
	logic [7:0]  pkt_type;
	logic [31:0] now_time;

	modport source (output valid, op, timestamp, origin_id, pkt_type, now_time, input ready);
	modport sink (input valid, op, timestamp, origin_id, pkt_type, now_time, output ready);
endinterface

// result word out of the filter
interface bdf_out_if;
	logic        valid;
	logic        ready;
	logic        seen;
	logic        cleared;
	logic [31:0] entries_added;

	modport source (output valid, seen, cleared, entries_added, input ready);
	modport sink (input valid, seen, cleared, entries_added, output ready);
endinterface

// clear interval register write
interface bdf_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] clear_interval;

	modport source (output valid, clear_interval, input ready);
	modport sink (input valid, clear_interval, output ready);
endinterface

FILE: rtl/bdf_hash.sv
`timescale 1ns / 1ps

module bdf_hash import bdf_pkg::*; #(
	parameter int BLOOM_BITS = 4096,
	parameter int ID_BYTES   = 8,
	localparam int IDX_W     = $clog2(BLOOM_BITS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [31:0]      seed,
	input  logic [63:0]      timestamp,
	input  logic [63:0]      origin_id,
	input  logic [7:0]       pkt_type,
	output logic             done,
	output logic [IDX_W-1:0] idx
);

	// reciprocal of the store size for the modulo step
	localparam longint unsigned RECIP64 = (64'd1 << 32) / BLOOM_BITS;
	localparam logic [31:0]     RECIP   = 32'(RECIP64);
	localparam int              Q_W     = 33 - IDX_W;
	localparam logic [31:0]     BB      = 32'(BLOOM_BITS);
	localparam logic [IDX_W:0]  BB_R    = (IDX_W+1)'(BLOOM_BITS);

	typedef enum logic [2:0] {
		H_IDLE,
		H_ROUND,
		H_FIN,
		H_RED,
		H_QB,
		H_DONE
	} hstate_t;

	hstate_t               state_q;
	logic [BYTE_CNT_W-1:0] byte_q;
	logic [31:0]           h_q;
	logic [Q_W-1:0]        q_q;
	logic [IDX_W:0]        r_q;

	logic [7:0]  byte_sel;
	logic [31:0] mixed;
	logic [31:0] rotated;
	logic [63:0] round_prod;
	logic [31:0] fold16;
	logic [63:0] fin_prod;
	logic [31:0] fold13;
	logic [63:0] recip_prod;
	logic [63:0] qb_prod;
	logic [31:0] residue;
	logic [IDX_W:0] r_sub;

	// one mixing round per cycle
	always_comb begin
		byte_sel   = origin_id[{byte_q, 3'b000} +: 8];
		mixed      = h_q ^ ({24'd0, byte_sel} << {byte_q[1:0], 3'b000});
		rotated    = {mixed[18:0], mixed[31:19]};
		round_prod = 64'(rotated) * 64'(ROUND_MUL);
		fold16     = h_q ^ (h_q >> 16);
		fin_prod   = 64'(fold16) * 64'(FINAL_MUL);
		fold13     = h_q ^ (h_q >> 13);
		recip_prod = 64'(fold13) * 64'(RECIP);
		qb_prod    = 64'(q_q) * 64'(BB);
		residue    = h_q - qb_prod[31:0];
		r_sub      = r_q - BB_R;
	end

	// quotient estimate is low by at most one, so one correcting subtract
	assign idx  = (r_q >= BB_R) ? r_sub[IDX_W-1:0] : r_q[IDX_W-1:0];
	assign done = (state_q == H_DONE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			byte_q  <= '0;
		end else begin
			case (state_q)
				H_IDLE: begin
					if (start) begin
						state_q <= H_ROUND;
						byte_q  <= '0;
					end
				end
				H_ROUND: begin
					if (byte_q == BYTE_CNT_W'(ID_BYTES - 1)) begin
						state_q <= H_FIN;
					end else begin
						byte_q <= byte_q + 1'b1;
					end
				end
				H_FIN:   state_q <= H_RED;
				H_RED:   state_q <= H_QB;
				H_QB:    state_q <= H_DONE;
				H_DONE:  state_q <= H_IDLE;
				default: state_q <= H_IDLE;
			endcase
		end
	end

	// hash datapath
	always_ff @(posedge clk) begin
		case (state_q)
			H_IDLE: begin
				if (start) begin
					h_q <= seed ^ timestamp[31:0] ^ timestamp[63:32] ^ {24'd0, pkt_type};
				end
			end
			H_ROUND: h_q <= round_prod[31:0];
			H_FIN:   h_q <= fin_prod[31:0];
			H_RED: begin
				h_q <= fold13;
				q_q <= recip_prod[32 +: Q_W];
			end
			H_QB:    r_q <= residue[IDX_W:0];
			default: ;
		endcase
	end

endmodule

FILE: rtl/bdf_store.sv
`timescale 1ns / 1ps

module bdf_store import bdf_pkg::*; #(
	parameter int ROWS = 128,
	localparam int AW  = $clog2(ROWS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  store_ctl_t          ctl,
	input  logic [AW-1:0]       rd_addr,
	output logic [ROW_BITS-1:0] rd_data,
	input  logic [AW-1:0]       wr_addr,
	input  logic [ROW_BITS-1:0] wr_data,
	output logic                busy
);

	logic [ROW_BITS-1:0] mem [ROWS];
	logic [ROW_BITS-1:0] rd_data_q;
	logic                busy_q;
	logic [AW-1:0]       ptr_q;

	logic                we;
	logic [AW-1:0]       wa;
	logic [ROW_BITS-1:0] wd;

	// clearing sweep, one row a cycle, also run straight after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			ptr_q  <= '0;
		end else if (busy_q) begin
			if (ptr_q == AW'(ROWS - 1)) begin
				busy_q <= 1'b0;
				ptr_q  <= '0;
			end else begin
				ptr_q <= ptr_q + 1'b1;
			end
		end else if (ctl.clear_req) begin
			busy_q <= 1'b1;
			ptr_q  <= '0;
		end
	end

	// write port shared between sweep and updates
	always_comb begin
		we = busy_q | ctl.wr_en;
		wa = busy_q ? ptr_q : wr_addr;
		wd = busy_q ? '0 : wr_data;
	end

	// row memory, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = busy_q;

endmodule

FILE: rtl/bloom_dedup_filter_unit.sv
`timescale 1ns / 1ps

// Bloom filter duplicate detector with three seeded hashes.
// pkt: one word per packet lookup or time tick (op, timestamp, origin_id,
//   pkt_type, now_time), taken when valid and ready are both high.
// res: one word per pkt word (seen, cleared, entries_added), held in an
//   output register until taken; a new pkt word is taken while it waits.
// cfg: writes clear_interval; a write of zero stores 300000. Always ready.
// Flow: the three hash lanes run together, one mixing round per cycle.
//   Three row reads on the single memory read port then follow, and an
//   add writes three rows back. A tick that falls due clears the store
//   with a sweep over the memory rows. The next pkt word is taken only
//   once the result of the last one has gone to the output register.
// Reset: the same row sweep zeroes the store while pkt ready stays low;
//   cfg writes are taken throughout.
// When res is stalled a finished word waits in the sequencer, and pkt ready
//   stays low until the output register is free again.
module bloom_dedup_filter_unit import bdf_pkg::*; #(
	parameter int BLOOM_BITS = 4096,
	parameter int ID_BYTES   = 8
) (
	input logic      clk,
	input logic      arst_n,
	bdf_in_if.sink   pkt,
	bdf_out_if.source res,
	bdf_cfg_if.sink  cfg
);

	localparam int IDX_W  = $clog2(BLOOM_BITS);
	localparam int ROWS   = (BLOOM_BITS + ROW_BITS - 1) / ROW_BITS;
	localparam int ROW_AW = $clog2(ROWS);

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_HSTART,
		S_HASH,
		S_RD,
		S_EVAL,
		S_WR,
		S_TICK,
		S_CLR,
		S_DONE
	} state_t;

	state_t      state_q;
	logic [1:0]  k_q;
	logic [31:0] interval_q;
	logic [31:0] last_q;
	logic [31:0] count_q;
	logic        seen_q;
	logic        cleared_q;
	logic        out_valid_q;
	logic        out_seen_q;
	logic        out_cleared_q;
	logic [31:0] out_entries_q;

	op_t                 op_q;
	logic [63:0]         ts_q;
	logic [63:0]         sender_q;
	logic [7:0]          type_q;
	logic [31:0]         now_q;
	logic [IDX_W-1:0]    idx_q [NUM_HASH];
	logic [ROW_BITS-1:0] row_q [NUM_HASH];

	logic                hash_start;
	logic [NUM_HASH-1:0] hash_done;
	logic [IDX_W-1:0]    lane_idx [NUM_HASH];

	store_ctl_t          ctl;
	logic [ROW_BITS-1:0] rd_data;
	logic [ROW_BITS-1:0] wr_data;
	logic                store_busy;

	logic [1:0]          ksel;
	logic [IDX_W-1:0]    cur_idx;
	logic [ROW_AW-1:0]   cur_row;
	logic [NUM_HASH-1:0] hit;
	logic                seen_now;
	logic                do_add;
	logic [ROW_BITS-1:0] wmask;
	logic [31:0]         elapsed;
	logic                due;
	logic                out_load;

	// three hash lanes in lockstep
	assign hash_start = (state_q == S_HSTART);

	for (genvar g = 0; g < NUM_HASH; g++) begin : g_lane
		bdf_hash #(
			.BLOOM_BITS (BLOOM_BITS),
			.ID_BYTES   (ID_BYTES)
		) u_hash (
			.clk       (clk),
			.arst_n    (arst_n),
			.start     (hash_start),
			.seed      (SEEDS[g]),
			.timestamp (ts_q),
			.origin_id (sender_q),
			.pkt_type  (type_q),
			.done      (hash_done[g]),
			.idx       (lane_idx[g])
		);
	end

	// bit store
	bdf_store #(
		.ROWS (ROWS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.rd_addr (cur_row),
		.rd_data (rd_data),
		.wr_addr (cur_row),
		.wr_data (wr_data),
		.busy    (store_busy)
	);

	// row selection and bit test
	always_comb begin
		ksel     = (k_q == 2'd3) ? 2'd2 : k_q;
		cur_idx  = idx_q[ksel];
		cur_row  = cur_idx[IDX_W-1:ROW_SEL_W];
		for (int j = 0; j < NUM_HASH; j++) begin
			hit[j] = row_q[j][idx_q[j][ROW_SEL_W-1:0]];
		end
		seen_now = &hit;
		do_add   = (op_q == OP_ADD) || ((op_q == OP_CHECK_ADD) && !seen_now);
	end

	// merge every index that falls in the row being written
	always_comb begin
		wmask = '0;
		for (int j = 0; j < NUM_HASH; j++) begin
			if (idx_q[j][IDX_W-1:ROW_SEL_W] == cur_row) begin
				wmask[idx_q[j][ROW_SEL_W-1:0]] = 1'b1;
			end
		end
		wr_data = row_q[ksel] | wmask;
	end

	// tick interval check, wrap-around elapsed time
	always_comb begin
		elapsed = now_q - last_q;
		due     = (elapsed >= interval_q);
	end

	always_comb begin
		ctl.rd_en     = (state_q == S_RD) && (k_q != 2'd3);
		ctl.wr_en     = (state_q == S_WR);
		ctl.clear_req = (state_q == S_TICK) && due;
		out_load      = (state_q == S_DONE) && (!out_valid_q || res.ready);
	end

	assign pkt.ready         = (state_q == S_IDLE);
	assign cfg.ready         = 1'b1;
	assign res.valid         = out_valid_q;
	assign res.seen          = out_seen_q;
	assign res.cleared       = out_cleared_q;
	assign res.entries_added = out_entries_q;

	// sequencer, filter state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_INIT;
			k_q           <= '0;
			interval_q    <= DEFAULT_INTERVAL;
			last_q        <= '0;
			count_q       <= '0;
			seen_q        <= 1'b0;
			cleared_q     <= 1'b0;
			out_valid_q   <= 1'b0;
			out_seen_q    <= 1'b0;
			out_cleared_q <= 1'b0;
			out_entries_q <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				interval_q <= (cfg.clear_interval == 32'd0) ? DEFAULT_INTERVAL
				                                            : cfg.clear_interval;
			end

			if (out_load) begin
				out_valid_q   <= 1'b1;
				out_seen_q    <= seen_q;
				out_cleared_q <= cleared_q;
				out_entries_q <= count_q;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_INIT: begin
					if (!store_busy) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (pkt.valid) begin
						state_q <= (op_t'(pkt.op) == OP_TICK) ? S_TICK : S_HSTART;
					end
				end
				S_HSTART: state_q <= S_HASH;
				S_HASH: begin
					if (&hash_done) begin
						state_q <= S_RD;
						k_q     <= '0;
					end
				end
				S_RD: begin
					k_q <= k_q + 1'b1;
					if (k_q == 2'd3) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					seen_q    <= seen_now;
					cleared_q <= 1'b0;
					k_q       <= '0;
					if (do_add) begin
						count_q <= count_q + 32'd1;
						state_q <= S_WR;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_WR: begin
					k_q <= k_q + 1'b1;
					if (k_q == 2'd2) begin
						state_q <= S_DONE;
					end
				end
				S_TICK: begin
					seen_q <= 1'b0;
					if (due) begin
						count_q   <= '0;
						last_q    <= now_q;
						cleared_q <= 1'b1;
						state_q   <= S_CLR;
					end else begin
						cleared_q <= 1'b0;
						state_q   <= S_DONE;
					end
				end
				S_CLR: begin
					if (!store_busy) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item, index and row registers
	always_ff @(posedge clk) begin
		if (pkt.valid && pkt.ready) begin
			op_q     <= op_t'(pkt.op);
			ts_q     <= pkt.timestamp;
			sender_q <= pkt.origin_id;
			type_q   <= pkt.pkt_type;
			now_q    <= pkt.now_time;
		end
		if ((state_q == S_HASH) && (&hash_done)) begin
			for (int j = 0; j < NUM_HASH; j++) begin
				idx_q[j] <= lane_idx[j];
			end
		end
		if ((state_q == S_RD) && (k_q != 2'd0)) begin
			row_q[k_q - 2'd1] <= rd_data;
		end
	end

endmodule
